// File: hdl/char_lcd_nibble_controller_assert.svh
// assertion macros for the character lcd nibble controller
// no dependencies, included by the top level only
`ifndef CHAR_LCD_NIBBLE_CONTROLLER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_CONTROLLER_ASSERT_SVH

// condition that holds at every clock edge outside reset
`define CLCD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication outside reset
`define CLCD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hdl/clcd_pkg.sv
// shared types, bus constants and glyph/digit tables of the lcd controller
// no dependencies
package clcd_pkg;

  typedef enum logic [2:0] {
    FUNC_INIT  = 3'd0,
    FUNC_CLEAR = 3'd1,
    FUNC_GOTO  = 3'd2,
    FUNC_PUT   = 3'd3,
    FUNC_PRINT = 3'd4,
    FUNC_BIG   = 3'd5,
    FUNC_GLYPH = 3'd6
  } func_e;

  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
  localparam logic [7:0] LCD_SET_CGRAM = 8'h40;
  localparam logic [7:0] LCD_FUNC_SET  = 8'b0010_1000;
  localparam logic [7:0] LCD_DISP_OFF  = 8'b0000_1000;
  localparam logic [7:0] LCD_CLR_DISP  = 8'h01;
  localparam logic [7:0] LCD_ENTRY     = 8'b0000_0110;
  localparam logic [7:0] LCD_DISP_ON   = 8'b0000_1100;
  localparam logic [3:0] LCD_WAKE_NIB  = 4'b0011;
  localparam logic [3:0] LCD_4BIT_NIB  = 4'b0010;

  typedef struct packed {
    logic [5:0] columns;
    logic [2:0] rows;
  } cfg_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] char_code;
    logic       start_of_text;
    logic [7:0] digit;
    logic [2:0] glyph;
  } cmd_t;

  typedef struct packed {
    func_e      func;
    logic [7:0] addr0;
    logic [7:0] addr1;
    logic [7:0] char_code;
    logic [3:0] digit;
    logic [2:0] glyph;
  } desc_t;

  typedef struct packed {
    logic       strobe_res;
    logic       reg_select;
    logic [3:0] nibble;
    logic [6:0] wait_ms;
    logic       last;
  } result_t;

  typedef struct packed {
    logic cmd_pop;
    logic out_push;
  } seq_ctl_t;

  localparam logic [4:0] GLYPH_ROWS [8][8] = '{
    '{5'h07, 5'h0F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F},
    '{5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h0F, 5'h07},
    '{5'h1C, 5'h1E, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F},
    '{5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1E, 5'h1C},
    '{5'h1F, 5'h1F, 5'h1F, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
    '{5'h1F, 5'h1F, 5'h1F, 5'h00, 5'h00, 5'h00, 5'h1F, 5'h1F},
    '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F, 5'h1F, 5'h1F},
    '{5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F}
  };

  // 32 is a blank cell
  localparam logic [7:0] DIGIT_CELLS [10][6] = '{
    '{8'd0, 8'd4, 8'd2, 8'd1, 8'd6, 8'd3},
    '{8'd4, 8'd2, 8'd32, 8'd6, 8'd7, 8'd6},
    '{8'd5, 8'd5, 8'd2, 8'd1, 8'd6, 8'd6},
    '{8'd5, 8'd5, 8'd2, 8'd6, 8'd6, 8'd3},
    '{8'd1, 8'd6, 8'd7, 8'd32, 8'd32, 8'd7},
    '{8'd1, 8'd5, 8'd5, 8'd6, 8'd6, 8'd3},
    '{8'd0, 8'd5, 8'd5, 8'd1, 8'd6, 8'd3},
    '{8'd4, 8'd4, 8'd2, 8'd32, 8'd32, 8'd7},
    '{8'd0, 8'd5, 8'd2, 8'd1, 8'd6, 8'd3},
    '{8'd0, 8'd5, 8'd2, 8'd6, 8'd6, 8'd3}
  };

  function automatic logic [7:0] digit_cell(logic [3:0] dig, logic [2:0] idx);
    logic [7:0] v;
    v = 8'd0;
    if (dig <= 4'd9 && idx <= 3'd5) begin
      v = DIGIT_CELLS[dig][idx];
    end
    return v;
  endfunction

  // one bus result of the power-up sequence
  function automatic result_t init_result(logic [4:0] step);
    result_t    r;
    logic [4:0] j;
    logic [7:0] b;
    logic [6:0] w;
    j = step - 5'd5;
    b = 8'd0;
    w = 7'd0;
    r.strobe_res = 1'b1;
    r.reg_select = RS_CMD;
    r.last       = (step == 5'd14);
    case (j[3:1])
      3'd0:    begin b = LCD_FUNC_SET; w = 7'd0; end
      3'd1:    begin b = LCD_DISP_OFF; w = 7'd1; end
      3'd2:    begin b = LCD_CLR_DISP; w = 7'd3; end
      3'd3:    begin b = LCD_ENTRY;    w = 7'd1; end
      3'd4:    begin b = LCD_DISP_ON;  w = 7'd1; end
      default: begin b = 8'd0;         w = 7'd0; end
    endcase
    r.nibble  = j[0] ? b[3:0] : b[7:4];
    r.wait_ms = j[0] ? w : 7'd0;
    case (step)
      5'd0: begin
        r.strobe_res = 1'b0;
        r.nibble     = 4'd0;
        r.wait_ms    = 7'd100;
      end
      5'd1:    begin r.nibble = LCD_WAKE_NIB; r.wait_ms = 7'd5; end
      5'd2:    begin r.nibble = LCD_WAKE_NIB; r.wait_ms = 7'd1; end
      5'd3:    begin r.nibble = LCD_WAKE_NIB; r.wait_ms = 7'd1; end
      5'd4:    begin r.nibble = LCD_4BIT_NIB; r.wait_ms = 7'd1; end
      default: ;
    endcase
    return r;
  endfunction

  // result number step of the command d; bytes go high nibble first
  function automatic result_t seq_result(desc_t d, logic [4:0] step);
    result_t    r;
    logic [3:0] k;
    logic [7:0] b;
    logic       rs;
    logic [6:0] w;
    logic       fin;
    logic [3:0] kk;
    k   = step[4:1];
    b   = 8'd0;
    rs  = RS_CMD;
    w   = 7'd0;
    fin = 1'b0;
    kk  = k - 4'd1;
    case (d.func)
      FUNC_CLEAR: begin
        b = LCD_CLR_DISP; w = 7'd3; fin = (k == 4'd0);
      end
      FUNC_GOTO: begin
        b = d.addr0; fin = (k == 4'd0);
      end
      FUNC_PUT: begin
        b = d.char_code; rs = RS_DATA; fin = (k == 4'd0);
      end
      FUNC_PRINT: begin
        if (k == 4'd0) begin
          b = d.addr0;
        end else begin
          b = d.char_code; rs = RS_DATA;
        end
        fin = (k == 4'd1);
      end
      FUNC_BIG: begin
        if (k == 4'd0) begin
          b = d.addr0;
        end else if (k == 4'd4) begin
          b = d.addr1;
        end else begin
          rs = RS_DATA;
          b  = digit_cell(d.digit, (k < 4'd4) ? kk[2:0] : 3'(k - 4'd2));
        end
        fin = (k == 4'd7);
      end
      FUNC_GLYPH: begin
        if (k == 4'd0) begin
          b = LCD_SET_CGRAM + {2'b00, d.glyph, 3'b000};
        end else begin
          rs = RS_DATA;
          b  = {3'b000, GLYPH_ROWS[d.glyph][kk[2:0]]};
        end
        fin = (k == 4'd8);
      end
      default: fin = 1'b1;
    endcase
    r.strobe_res = 1'b1;
    r.reg_select = rs;
    r.nibble     = step[0] ? b[3:0] : b[7:4];
    r.wait_ms    = step[0] ? w : 7'd0;
    r.last       = fin && step[0];
    if (d.func == FUNC_INIT) begin
      r = init_result(step);
    end
    return r;
  endfunction

endpackage

// File: hdl/char_lcd_nibble_controller.sv
// character lcd command engine for a 4-bit bus: a command is registered in the
// command queue and its results in the result queue before they reach the ports;
// results then stream one per cycle while the result queue has room. a command
// has 2 to 18 results (init 15). commands queue two deep behind the sequencer.
// reset: queues empty, cursor at 0,0, columns 16, rows 2
`include "char_lcd_nibble_controller_assert.svh"
module char_lcd_nibble_controller #(
  parameter int unsigned MAX_ROWS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [2:0] func_i,
  input  logic [7:0] column_i,
  input  logic [7:0] row_i,
  input  logic [7:0] char_code_i,
  input  logic       start_of_text_i,
  input  logic [7:0] digit_i,
  input  logic [2:0] glyph_i,
  output logic       empty,
  input  logic       pop,
  output logic       strobe_res_o,
  output logic       reg_select_o,
  output logic [3:0] nibble_o,
  output logic [6:0] wait_ms_o,
  output logic       last_o,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [5:0] cfg_data_i
);
  import clcd_pkg::*;

  localparam int unsigned CmdDepth = 2;
  localparam int unsigned OutDepth = 2;

  logic [5:0] columns_q;
  logic [2:0] rows_q;
  cfg_t       cfg;
  cmd_t       cmd;
  desc_t      front_desc, head_desc;
  logic       enq, accept, cmd_empty, out_full;
  seq_ctl_t   seq_ctl;
  result_t    seq_res, out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= 6'd16;
      rows_q    <= 3'd2;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_COLUMNS) begin
        columns_q <= cfg_data_i;
      end else begin
        rows_q <= cfg_data_i[2:0];
      end
    end
  end

  assign cfg.columns = columns_q;
  assign cfg.rows    = rows_q;

  assign cmd.func          = func_i;
  assign cmd.column        = column_i;
  assign cmd.row           = row_i;
  assign cmd.char_code     = char_code_i;
  assign cmd.start_of_text = start_of_text_i;
  assign cmd.digit         = digit_i;
  assign cmd.glyph         = glyph_i;

  assign accept = push && !full;

  clcd_front #(.MaxRows(MAX_ROWS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .cmd_i   (cmd),
    .cfg_i   (cfg),
    .enq_o   (enq),
    .desc_o  (front_desc)
  );

  clcd_fifo #(.Width($bits(desc_t)), .Depth(CmdDepth)) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (enq),
    .data_i (front_desc),
    .full_o (full),
    .pop_i  (seq_ctl.cmd_pop),
    .data_o (head_desc),
    .empty_o(cmd_empty)
  );

  clcd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .desc_i     (head_desc),
    .cmd_empty_i(cmd_empty),
    .out_full_i (out_full),
    .ctl_o      (seq_ctl),
    .res_o      (seq_res)
  );

  clcd_fifo #(.Width($bits(result_t)), .Depth(OutDepth)) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (seq_ctl.out_push),
    .data_i (seq_res),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (out_res),
    .empty_o(empty)
  );

  assign strobe_res_o = out_res.strobe_res;
  assign reg_select_o = out_res.reg_select;
  assign nibble_o     = out_res.nibble;
  assign wait_ms_o    = out_res.wait_ms;
  assign last_o       = out_res.last;

  // a command leaves the queue exactly with its final result
  `CLCD_ASSERT_ALWAYS(a_pop_on_last, clk_i, rst_ni, seq_ctl.cmd_pop == (seq_ctl.out_push && seq_res.last), "command pop out of step")
  // the sequencer never idles while it has a command and room for a result
  `CLCD_ASSERT_IMPLY(a_no_idle, clk_i, rst_ni, !cmd_empty && !out_full, seq_ctl.out_push, "sequencer idle")

endmodule

// File: hdl/clcd_fifo.sv
// small register queue used for commands and for bus results
// depends on nothing
module clcd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hdl/clcd_front.sv
// command front end: classifies commands, clamps positions, keeps the print cursor
// depends on clcd_pkg
module clcd_front #(
  parameter int unsigned MaxRows = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  clcd_pkg::cmd_t cmd_i,
  input  clcd_pkg::cfg_t cfg_i,
  output logic           enq_o,
  output clcd_pkg::desc_t desc_o
);
  import clcd_pkg::*;

  localparam logic [2:0] MaxRowsL = 3'(MaxRows);

  logic [7:0] cur_col_q, cur_col_d, cur_row_q, cur_row_d;
  logic [7:0] src_col, src_row, wrap_col, wrap_row;
  logic [7:0] addr_plain, addr_next, addr_print;
  logic [2:0] limit;
  logic       col_over;

  function automatic logic [7:0] goto_addr(logic [7:0] col, logic [7:0] row,
                                           logic [5:0] columns, logic [2:0] lim);
    logic [7:0] c;
    logic [7:0] r;
    logic [8:0] base;
    logic [8:0] sum;
    c    = (col >= {2'b00, columns}) ? 8'd0 : col;
    r    = (row >= {5'b00000, lim}) ? 8'd0 : row;
    base = (r[0] ? 9'h040 : 9'h000) + ((r >= 8'd2) ? {3'b000, columns} : 9'd0);
    sum  = base + {1'b0, c};
    return LCD_SET_DDRAM | sum[7:0];
  endfunction

  always_comb begin
    limit    = (cfg_i.rows < MaxRowsL) ? cfg_i.rows : MaxRowsL;
    src_col  = cmd_i.start_of_text ? cmd_i.column : cur_col_q;
    src_row  = cmd_i.start_of_text ? cmd_i.row : cur_row_q;
    col_over = (src_col >= {2'b00, cfg_i.columns});
    wrap_col = src_col;
    wrap_row = src_row;
    if (col_over && src_row >= {5'b00000, limit}) begin
      wrap_col = 8'd0;
      wrap_row = 8'd0;
    end else if (col_over) begin
      wrap_col = 8'd0;
      wrap_row = src_row + 8'd1;
    end
    addr_plain = goto_addr(cmd_i.column, cmd_i.row, cfg_i.columns, limit);
    addr_next  = goto_addr(cmd_i.column, cmd_i.row + 8'd1, cfg_i.columns, limit);
    addr_print = goto_addr(wrap_col, wrap_row, cfg_i.columns, limit);
  end

  always_comb begin
    desc_o.func      = func_e'(cmd_i.func);
    desc_o.addr0     = (cmd_i.func == FUNC_PRINT) ? addr_print : addr_plain;
    desc_o.addr1     = addr_next;
    desc_o.char_code = cmd_i.char_code;
    desc_o.digit     = cmd_i.digit[3:0];
    desc_o.glyph     = cmd_i.glyph;
    case (cmd_i.func)
      FUNC_INIT, FUNC_CLEAR, FUNC_GOTO, FUNC_PUT, FUNC_PRINT, FUNC_GLYPH:
        enq_o = accept_i;
      FUNC_BIG: enq_o = accept_i && (cmd_i.digit <= 8'd9);
      default:  enq_o = 1'b0;
    endcase
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    if (accept_i && cmd_i.func == FUNC_PRINT) begin
      cur_col_d = wrap_col + 8'd1;
      cur_row_d = wrap_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= 8'd0;
      cur_row_q <= 8'd0;
    end else begin
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
    end
  end

endmodule

// File: hdl/clcd_back.sv
// bus sequencer: expands the oldest queued command into nibble results
// depends on clcd_pkg
module clcd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  clcd_pkg::desc_t    desc_i,
  input  logic               cmd_empty_i,
  input  logic               out_full_i,
  output clcd_pkg::seq_ctl_t ctl_o,
  output clcd_pkg::result_t  res_o
);
  import clcd_pkg::*;

  logic [4:0] step_q, step_d;

  always_comb begin
    res_o          = seq_result(desc_i, step_q);
    ctl_o.out_push = !cmd_empty_i && !out_full_i;
    ctl_o.cmd_pop  = ctl_o.out_push && res_o.last;
    step_d         = step_q;
    if (ctl_o.out_push) begin
      step_d = res_o.last ? 5'd0 : step_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 5'd0;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// File: tb/clcd_checker.sv
// transaction checker for the character lcd nibble controller: predicts the
// nibble stream of each accepted command and compares it with the popped results
// depends on clcd_pkg for the func codes, register indexes and bus constants
module clcd_checker #(
  parameter int unsigned MAX_ROWS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_i,
  input  logic [2:0] func_i,
  input  logic [7:0] column_i,
  input  logic [7:0] row_i,
  input  logic [7:0] char_code_i,
  input  logic       start_of_text_i,
  input  logic [7:0] digit_i,
  input  logic [2:0] glyph_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  logic       strobe_res_i,
  input  logic       reg_select_i,
  input  logic [3:0] nibble_i,
  input  logic [6:0] wait_ms_i,
  input  logic       last_i,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [5:0] cfg_data_i,
  output int         errors_o,
  output int         pending_o
);
  import clcd_pkg::*;

  // cgram bitmaps of the eight custom cells, one row per entry
  localparam logic [4:0] CELL_BITMAP [8][8] = '{
    '{5'b00111, 5'b01111, 5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b11111},
    '{5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b01111, 5'b00111},
    '{5'b11100, 5'b11110, 5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b11111},
    '{5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b11110, 5'b11100},
    '{5'b11111, 5'b11111, 5'b11111, 5'b00000, 5'b00000, 5'b00000, 5'b00000, 5'b00000},
    '{5'b11111, 5'b11111, 5'b11111, 5'b00000, 5'b00000, 5'b00000, 5'b11111, 5'b11111},
    '{5'b00000, 5'b00000, 5'b00000, 5'b00000, 5'b00000, 5'b11111, 5'b11111, 5'b11111},
    '{5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b11111}
  };

  localparam logic [7:0] BLANK = 8'd32;

  // big digit layout: top row left to right, then bottom row
  localparam logic [7:0] BIG_DIGIT_CELLS [10][6] = '{
    '{8'd0, 8'd4, 8'd2, 8'd1, 8'd6, 8'd3},
    '{8'd4, 8'd2, BLANK, 8'd6, 8'd7, 8'd6},
    '{8'd5, 8'd5, 8'd2, 8'd1, 8'd6, 8'd6},
    '{8'd5, 8'd5, 8'd2, 8'd6, 8'd6, 8'd3},
    '{8'd1, 8'd6, 8'd7, BLANK, BLANK, 8'd7},
    '{8'd1, 8'd5, 8'd5, 8'd6, 8'd6, 8'd3},
    '{8'd0, 8'd5, 8'd5, 8'd1, 8'd6, 8'd3},
    '{8'd4, 8'd4, 8'd2, BLANK, BLANK, 8'd7},
    '{8'd0, 8'd5, 8'd2, 8'd1, 8'd6, 8'd3},
    '{8'd0, 8'd5, 8'd2, 8'd6, 8'd6, 8'd3}
  };

  logic [5:0] columns_q;
  logic [2:0] rows_q;
  logic [7:0] cursor_col_q;
  logic [7:0] cursor_row_q;
  result_t    bus_expected_q[$];
  int         mismatches;
  int         results_checked;

  assign errors_o = mismatches;

  task automatic report(string msg);
    $display("clcd_checker: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report($sformatf("result %0d: %s is %0d, expected %0d", results_checked, name,
                       got, want));
    end
  endtask

  function automatic logic [7:0] row_limit();
    return (rows_q < MAX_ROWS) ? 8'(rows_q) : 8'(MAX_ROWS);
  endfunction

  // set-ddram command byte for a position, out-of-range coordinates clamp to 0
  function automatic logic [7:0] ddram_cmd(logic [7:0] col, logic [7:0] row);
    logic [7:0] c;
    logic [7:0] r;
    logic [7:0] base;
    c = (col >= {2'b00, columns_q}) ? 8'd0 : col;
    r = (row >= row_limit()) ? 8'd0 : row;
    base = (r[0] ? 8'h40 : 8'h00) + ((r >= 8'd2) ? {2'b00, columns_q} : 8'd0);
    return LCD_SET_DDRAM | 8'(base + c);
  endfunction

  task automatic expect_nibble(logic strobe, logic rs, logic [3:0] nib, logic [6:0] ms);
    result_t r;
    r.strobe_res = strobe;
    r.reg_select = rs;
    r.nibble     = nib;
    r.wait_ms    = ms;
    r.last       = 1'b0;
    bus_expected_q.push_back(r);
  endtask

  task automatic expect_byte(logic rs, logic [7:0] b, logic [6:0] ms);
    expect_nibble(1'b1, rs, b[7:4], 7'd0);
    expect_nibble(1'b1, rs, b[3:0], ms);
  endtask

  task automatic predict_command();
    int         first;
    result_t    tail;
    logic [7:0] below;
    first = bus_expected_q.size();
    case (func_i)
      FUNC_INIT: begin
        expect_nibble(1'b0, RS_CMD, 4'd0, 7'd100);
        expect_nibble(1'b1, RS_CMD, LCD_WAKE_NIB, 7'd5);
        expect_nibble(1'b1, RS_CMD, LCD_WAKE_NIB, 7'd1);
        expect_nibble(1'b1, RS_CMD, LCD_WAKE_NIB, 7'd1);
        expect_nibble(1'b1, RS_CMD, LCD_4BIT_NIB, 7'd1);
        expect_byte(RS_CMD, LCD_FUNC_SET, 7'd0);
        expect_byte(RS_CMD, LCD_DISP_OFF, 7'd1);
        expect_byte(RS_CMD, LCD_CLR_DISP, 7'd3);
        expect_byte(RS_CMD, LCD_ENTRY, 7'd1);
        expect_byte(RS_CMD, LCD_DISP_ON, 7'd1);
      end
      FUNC_CLEAR: expect_byte(RS_CMD, LCD_CLR_DISP, 7'd3);
      FUNC_GOTO:  expect_byte(RS_CMD, ddram_cmd(column_i, row_i), 7'd0);
      FUNC_PUT:   expect_byte(RS_DATA, char_code_i, 7'd0);
      FUNC_PRINT: begin
        if (start_of_text_i) begin
          cursor_col_q = column_i;
          cursor_row_q = row_i;
        end
        // wrap past the last column; past the last row too goes home
        if (cursor_col_q >= {2'b00, columns_q} && cursor_row_q >= row_limit()) begin
          cursor_col_q = 8'd0;
          cursor_row_q = 8'd0;
        end else if (cursor_col_q >= {2'b00, columns_q}) begin
          cursor_col_q = 8'd0;
          cursor_row_q = cursor_row_q + 8'd1;
        end
        expect_byte(RS_CMD, ddram_cmd(cursor_col_q, cursor_row_q), 7'd0);
        expect_byte(RS_DATA, char_code_i, 7'd0);
        cursor_col_q = cursor_col_q + 8'd1;
      end
      FUNC_BIG: begin
        if (digit_i <= 8'd9) begin
          below = row_i + 8'd1;
          expect_byte(RS_CMD, ddram_cmd(column_i, row_i), 7'd0);
          for (int i = 0; i < 3; i++) begin
            expect_byte(RS_DATA, BIG_DIGIT_CELLS[digit_i][i], 7'd0);
          end
          expect_byte(RS_CMD, ddram_cmd(column_i, below), 7'd0);
          for (int i = 3; i < 6; i++) begin
            expect_byte(RS_DATA, BIG_DIGIT_CELLS[digit_i][i], 7'd0);
          end
        end
      end
      FUNC_GLYPH: begin
        expect_byte(RS_CMD, LCD_SET_CGRAM + {2'b00, glyph_i, 3'b000}, 7'd0);
        for (int i = 0; i < 8; i++) begin
          expect_byte(RS_DATA, {3'b000, CELL_BITMAP[glyph_i][i]}, 7'd0);
        end
      end
      default: ;
    endcase
    if (bus_expected_q.size() > first) begin
      tail = bus_expected_q[bus_expected_q.size() - 1];
      tail.last = 1'b1;
      bus_expected_q[bus_expected_q.size() - 1] = tail;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      columns_q    = 6'd16;
      rows_q       = 3'd2;
      cursor_col_q = 8'd0;
      cursor_row_q = 8'd0;
      bus_expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_COLUMNS) begin
          columns_q = cfg_data_i;
        end else begin
          rows_q = cfg_data_i[2:0];
        end
      end
      if (pop_i && !empty_i) begin
        if (bus_expected_q.size() == 0) begin
          report($sformatf("result %0d popped with no transaction expected",
                           results_checked));
        end else begin
          want = bus_expected_q.pop_front();
          check_field("strobe_res", 8'(strobe_res_i), 8'(want.strobe_res));
          check_field("reg_select", 8'(reg_select_i), 8'(want.reg_select));
          check_field("nibble", 8'(nibble_i), 8'(want.nibble));
          check_field("wait_ms", 8'(wait_ms_i), 8'(want.wait_ms));
          check_field("last", 8'(last_i), 8'(want.last));
        end
        results_checked++;
      end
      if (push_i && !full_i) begin
        predict_command();
      end
      pending_o <= bus_expected_q.size();
    end
  end

endmodule

// File: tb/tb_top.sv
// top of the lcd controller testbench: clock, reset, command and pop traffic,
// display geometry changes and the verdict
// depends on clcd_pkg, char_lcd_nibble_controller and clcd_checker
module tb_top;
  import clcd_pkg::*;

  localparam int         LIMIT_CYCLES = 4000;
  localparam int         HOLD_CYCLES  = 200;
  localparam int         QUIET_CYCLES = 10;
  localparam int         NUM_PHASES   = 6;
  localparam int         PHASE_ITEMS  = 57;
  localparam logic [2:0] FUNC_UNUSED  = 3'd7;

  // geometry per random phase, -1 picks a random value
  localparam int PHASE_COLS  [NUM_PHASES] = '{40, 1, 20, 0, -1, 16};
  localparam int PHASE_ROWS  [NUM_PHASES] = '{4, 7, 3, 0, -1, 1};
  localparam int PHASE_IDLE  [NUM_PHASES] = '{51, 0, 19, 0, 25, 10};
  localparam int PHASE_STALL [NUM_PHASES] = '{0, 51, 19, 51, 25, 10};

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       push            = 1'b0;
  logic       full;
  logic [2:0] cmd_func        = 3'd0;
  logic [7:0] cmd_column      = 8'd0;
  logic [7:0] cmd_row         = 8'd0;
  logic [7:0] cmd_char        = 8'd0;
  logic       cmd_sot         = 1'b0;
  logic [7:0] cmd_digit       = 8'd0;
  logic [2:0] cmd_glyph       = 3'd0;
  logic       empty;
  logic       pop             = 1'b0;
  logic       res_strobe;
  logic       res_rs;
  logic [3:0] res_nibble;
  logic [6:0] res_wait_ms;
  logic       res_last;
  logic       cfg_we          = 1'b0;
  logic       cfg_index       = 1'b0;
  logic [5:0] cfg_data        = 6'd0;

  int errors;
  int pending;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_reqs = 0;
  int holds_done = 0;
  int commands_sent = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int cfg_cols = 16;
  int cfg_rows = 2;

  always #2 clk_i = ~clk_i;

  char_lcd_nibble_controller dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .func_i         (cmd_func),
    .column_i       (cmd_column),
    .row_i          (cmd_row),
    .char_code_i    (cmd_char),
    .start_of_text_i(cmd_sot),
    .digit_i        (cmd_digit),
    .glyph_i        (cmd_glyph),
    .empty          (empty),
    .pop            (pop),
    .strobe_res_o   (res_strobe),
    .reg_select_o   (res_rs),
    .nibble_o       (res_nibble),
    .wait_ms_o      (res_wait_ms),
    .last_o         (res_last),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  clcd_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .func_i         (cmd_func),
    .column_i       (cmd_column),
    .row_i          (cmd_row),
    .char_code_i    (cmd_char),
    .start_of_text_i(cmd_sot),
    .digit_i        (cmd_digit),
    .glyph_i        (cmd_glyph),
    .empty_i        (empty),
    .pop_i          (pop),
    .strobe_res_i   (res_strobe),
    .reg_select_i   (res_rs),
    .nibble_i       (res_nibble),
    .wait_ms_i      (res_wait_ms),
    .last_i         (res_last),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  // result side: random stalls, and a long hold-off whenever one is requested
  always begin
    @(posedge clk_i);
    if (rst_ni && holds_done != hold_reqs) begin
      pop <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      holds_done++;
    end else begin
      pop <= rst_ni && ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        results_seen++;
      end
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= LIMIT_CYCLES) begin
          $display("tb_top: FAIL");
          $finish;
        end
      end
    end
  end

  function automatic cmd_t make_cmd(logic [2:0] f, logic [7:0] col, logic [7:0] row,
                                    logic [7:0] ch, logic sot, logic [7:0] dig,
                                    logic [2:0] gl);
    cmd_t c;
    c.func          = f;
    c.column        = col;
    c.row           = row;
    c.char_code     = ch;
    c.start_of_text = sot;
    c.digit         = dig;
    c.glyph         = gl;
    return c;
  endfunction

  function automatic cmd_t random_fields();
    return make_cmd(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 8'($urandom),
                    1'($urandom), 8'($urandom), 3'($urandom));
  endfunction

  // mostly near the visible area, sometimes anywhere in the field
  function automatic logic [7:0] pick_coord(int span);
    if ($urandom_range(0, 99) < 70) begin
      return 8'($urandom_range(0, span + 1));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // drives the command onto the ports and returns once the controller has accepted it
  task automatic send_cmd(cmd_t c);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push       <= 1'b1;
    cmd_func   <= c.func;
    cmd_column <= c.column;
    cmd_row    <= c.row;
    cmd_char   <= c.char_code;
    cmd_sot    <= c.start_of_text;
    cmd_digit  <= c.digit;
    cmd_glyph  <= c.glyph;
    do @(posedge clk_i); while (full);
    commands_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(int cols, int nrows);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COLUMNS;
    cfg_data  <= 6'(cols);
    @(posedge clk_i);
    // upper data bits are ignored by the rows register
    cfg_index <= CFG_ROWS;
    cfg_data  <= {3'($urandom), 3'(nrows)};
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cfg_cols  = cols;
    cfg_rows  = nrows;
  endtask

  task automatic issue_random_command();
    cmd_t c;
    int   pick;
    int   run;
    c    = random_fields();
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      c.func = FUNC_INIT;
    end else if (pick < 10) begin
      c.func = FUNC_CLEAR;
    end else if (pick < 25) begin
      c.func   = FUNC_GOTO;
      c.column = pick_coord(cfg_cols);
      c.row    = pick_coord(cfg_rows);
    end else if (pick < 37) begin
      c.func = FUNC_PUT;
    end else if (pick < 60) begin
      // a text run: often start near the right edge so the cursor wraps
      c.func          = FUNC_PRINT;
      c.start_of_text = ($urandom_range(0, 99) < 80);
      c.column        = $urandom_range(0, 1) ? 8'(cfg_cols - $urandom_range(0, 2))
                                             : pick_coord(cfg_cols);
      c.row           = pick_coord(cfg_rows);
      send_cmd(c);
      run = $urandom_range(1, 12);
      repeat (run) begin
        c = random_fields();
        c.func          = FUNC_PRINT;
        c.start_of_text = 1'b0;
        send_cmd(c);
      end
      return;
    end else if (pick < 78) begin
      c.func   = FUNC_BIG;
      c.column = pick_coord(cfg_cols);
      c.row    = pick_coord(cfg_rows);
      c.digit  = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 9))
                                              : 8'($urandom_range(10, 255));
    end else if (pick < 92) begin
      c.func = FUNC_GLYPH;
    end else if (pick < 96) begin
      c.func = FUNC_UNUSED;
    end
    send_cmd(c);
  endtask

  initial begin
    cmd_t directed_q[$];
    int   phase_start;
    int   cols;
    int   nrows;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed commands at the reset geometry of 16 columns by 2 rows
    directed_q.push_back(make_cmd(FUNC_INIT, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd0));
    directed_q.push_back(make_cmd(FUNC_CLEAR, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 3'd7));
    directed_q.push_back(make_cmd(FUNC_GOTO, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd0));
    directed_q.push_back(make_cmd(FUNC_GOTO, 8'd15, 8'd1, 8'd0, 1'b0, 8'd0, 3'd0));
    directed_q.push_back(make_cmd(FUNC_GOTO, 8'd16, 8'd0, 8'd0, 1'b0, 8'd0, 3'd0));
    directed_q.push_back(make_cmd(FUNC_GOTO, 8'd3, 8'd2, 8'd0, 1'b0, 8'd0, 3'd0));
    directed_q.push_back(make_cmd(FUNC_GOTO, 8'hFF, 8'hFF, 8'd0, 1'b0, 8'd0, 3'd0));
    directed_q.push_back(make_cmd(FUNC_PUT, 8'd0, 8'd0, 8'h00, 1'b0, 8'd0, 3'd0));
    directed_q.push_back(make_cmd(FUNC_PUT, 8'd0, 8'd0, 8'hFF, 1'b0, 8'd0, 3'd0));
    // wrap from the end of row 0 into row 1
    directed_q.push_back(make_cmd(FUNC_PRINT, 8'd14, 8'd0, 8'h41, 1'b1, 8'd0, 3'd0));
    directed_q.push_back(make_cmd(FUNC_PRINT, 8'hFF, 8'hFF, 8'h42, 1'b0, 8'd0, 3'd0));
    directed_q.push_back(make_cmd(FUNC_PRINT, 8'd0, 8'd0, 8'h43, 1'b0, 8'd0, 3'd0));
    directed_q.push_back(make_cmd(FUNC_PRINT, 8'd0, 8'd0, 8'h44, 1'b0, 8'd0, 3'd0));
    // past the last row and column goes home
    directed_q.push_back(make_cmd(FUNC_PRINT, 8'd20, 8'd5, 8'h45, 1'b1, 8'd0, 3'd0));
    directed_q.push_back(make_cmd(FUNC_PRINT, 8'hFF, 8'hFF, 8'hAA, 1'b1, 8'd0, 3'd0));
    directed_q.push_back(make_cmd(FUNC_PRINT, 8'd15, 8'd1, 8'h55, 1'b1, 8'd0, 3'd0));
    directed_q.push_back(make_cmd(FUNC_PRINT, 8'd0, 8'd0, 8'h56, 1'b0, 8'd0, 3'd0));
    directed_q.push_back(make_cmd(FUNC_BIG, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd0));
    directed_q.push_back(make_cmd(FUNC_BIG, 8'd13, 8'd1, 8'd0, 1'b0, 8'd9, 3'd0));
    directed_q.push_back(make_cmd(FUNC_BIG, 8'd2, 8'd0, 8'd0, 1'b0, 8'd10, 3'd0));
    directed_q.push_back(make_cmd(FUNC_BIG, 8'd2, 8'd0, 8'd0, 1'b0, 8'd255, 3'd0));
    directed_q.push_back(make_cmd(FUNC_GLYPH, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd0));
    directed_q.push_back(make_cmd(FUNC_GLYPH, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd7));
    directed_q.push_back(make_cmd(FUNC_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 3'd7));
    foreach (directed_q[i]) begin
      send_cmd(directed_q[i]);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      cols  = (PHASE_COLS[p] < 0) ? $urandom_range(1, 40) : PHASE_COLS[p];
      nrows = (PHASE_ROWS[p] < 0) ? $urandom_range(0, 7) : PHASE_ROWS[p];
      write_config(cols, nrows);
      sender_idle_pct    = PHASE_IDLE[p];
      receiver_stall_pct = PHASE_STALL[p];
      // fill the block up while results are held back
      if (p == 2) begin
        hold_reqs++;
      end
      phase_start = commands_sent;
      while (commands_sent - phase_start < PHASE_ITEMS) begin
        issue_random_command();
      end
    end
    wait_drained();

    $display("tb_top: %0d commands, %0d bus results checked over %0d geometries", commands_sent,
             results_seen, NUM_PHASES + 1);
    $display("tb_top: idle and stall phases, one full-queue hold-off, %0d mismatches", errors);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: char_lcd_nibble_controller.f
+incdir+hdl
hdl/clcd_pkg.sv
hdl/clcd_fifo.sv
hdl/clcd_front.sv
hdl/clcd_back.sv
hdl/char_lcd_nibble_controller.sv
tb/clcd_checker.sv
tb/tb_top.sv
